// ----- design/modular_exponentiation_core_assert.svh -----
// Assertion macros shared by the modular exponentiation RTL.
// Included by files that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Implication checked on every clock, idle while reset is held.
`define MEC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation core.
// No dependencies.
`default_nettype none
package mexp_pkg;
    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH + 1);
    localparam int TDATA_IN_WIDTH = 3 * OPERAND_WIDTH;
    localparam int TDATA_OUT_WIDTH = ((OPERAND_WIDTH + 1 + 7) / 8) * 8;

    typedef logic [OPERAND_WIDTH-1:0] word_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_FIND_MSB,
        ST_SQUARE,
        ST_MULT,
        ST_NEXT_BIT,
        ST_DONE
    } state_t;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_START,
        OP_SQ_START,
        OP_MUL_START,
        OP_SCAN_SHIFT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic unit_busy;
        logic expo_top;
        logic expo_zero;
        logic bits_left;
    } status_t;
endpackage
`default_nettype wire

// ----- design/modular_exponentiation_core.sv -----
// Top level of the modular exponentiation core: stream ports, controller, datapath.
// Depends on mexp_pkg, mexp_ctrl, mexp_datapath.
//
//  channel | direction | tdata (low bit up)                            | tuser
//  s_      | in        | base_value, exponent_value, modulus_value     | -
//  m_      | out       | power_result, modulus_error, zero fill        | -
//
// One item at a time; modular products come from the bit-serial multiply unit.
// A result waits in m_ until taken; s_tready stays low until then.
// Reset is synchronous, active low, and clears only the control state.
`default_nettype none
module modular_exponentiation_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // base_value, exponent_value, modulus_value
    input  wire logic [mexp_pkg::TDATA_IN_WIDTH-1:0]  s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // power_result, modulus_error, zero fill
    output logic [mexp_pkg::TDATA_OUT_WIDTH-1:0]      m_tdata
);
    localparam int W = mexp_pkg::OPERAND_WIDTH;

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;
    mexp_pkg::word_t   result;
    logic              start;

    assign start = s_tvalid && s_tready;

    mexp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .out_ready(m_tready),
        .status(status), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    mexp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .base_in(s_tdata[W-1:0]), .expo_in(s_tdata[2*W-1:W]),
        .modu_in(s_tdata[3*W-1:2*W]),
        .cmd(cmd), .status(status), .result(result)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[W-1:0] = status.mod_zero ? '0 : result;
        m_tdata[W] = status.mod_zero;
    end
endmodule
`default_nettype wire

// ----- design/mexp_datapath.sv -----
// Datapath: operand registers, bit-serial modular multiply/reduce unit, exponent scan.
// Depends on mexp_pkg.
`default_nettype none
`include "modular_exponentiation_core_assert.svh"
module mexp_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mexp_pkg::word_t   base_in,
    input  wire mexp_pkg::word_t   expo_in,
    input  wire mexp_pkg::word_t   modu_in,
    input  wire mexp_pkg::cmd_t    cmd,
    output mexp_pkg::status_t      status,
    output mexp_pkg::word_t        result
);
    localparam int W = mexp_pkg::OPERAND_WIDTH;

    mexp_pkg::word_t base_reg, base_next;
    mexp_pkg::word_t expo_reg, expo_next;
    mexp_pkg::word_t modu_reg, modu_next;
    mexp_pkg::word_t acc_reg, acc_next;
    // unit: prod = prod*2 (+x) mod m, one multiplier bit per cycle
    mexp_pkg::word_t prod_reg, prod_next;
    mexp_pkg::word_t x_reg, x_next;
    mexp_pkg::word_t y_reg, y_next;
    mexp_pkg::cnt_t  ucnt_reg, ucnt_next;
    logic            to_base_reg, to_base_next;
    mexp_pkg::cnt_t  bits_reg, bits_next;

    logic [W:0] dbl, dbl_red, add_sum, add_red;
    mexp_pkg::word_t step_val;

    always_comb begin
        dbl     = {prod_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modu_reg}) ? dbl - {1'b0, modu_reg} : dbl;
        add_sum = dbl_red + {1'b0, x_reg};
        add_red = (add_sum >= {1'b0, modu_reg}) ? add_sum - {1'b0, modu_reg} : add_sum;
        step_val = y_reg[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
    end

    always_comb begin
        base_next = base_reg;
        expo_next = expo_reg;
        modu_next = modu_reg;
        acc_next = acc_reg;
        prod_next = prod_reg;
        x_next = x_reg;
        y_next = y_reg;
        ucnt_next = ucnt_reg;
        to_base_next = to_base_reg;
        bits_next = bits_reg;
        if (ucnt_reg != '0) begin
            prod_next = step_val;
            y_next = {y_reg[W-2:0], 1'b0};
            ucnt_next = ucnt_reg - mexp_pkg::cnt_t'(1);
            if (ucnt_reg == mexp_pkg::cnt_t'(1)) begin
                if (to_base_reg) begin
                    base_next = step_val;
                end else begin
                    acc_next = step_val;
                end
            end
        end
        case (cmd.op)
            mexp_pkg::OP_LOAD: begin
                base_next = base_in;
                expo_next = expo_in;
                modu_next = modu_in;
                // 1 mod n: zero when n is one
                acc_next = (modu_in == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
                bits_next = mexp_pkg::cnt_t'(W);
            end
            mexp_pkg::OP_RED_START: begin
                // base mod n = 1 * base mod n: x = 1, base taken bitwise via y
                prod_next = '0;
                x_next = mexp_pkg::word_t'(1);
                y_next = base_reg;
                ucnt_next = mexp_pkg::cnt_t'(W);
                to_base_next = 1'b1;
            end
            mexp_pkg::OP_SQ_START: begin
                prod_next = '0;
                x_next = acc_reg;
                y_next = acc_reg;
                ucnt_next = mexp_pkg::cnt_t'(W);
                to_base_next = 1'b0;
            end
            mexp_pkg::OP_MUL_START: begin
                prod_next = '0;
                x_next = base_reg;
                y_next = acc_reg;
                ucnt_next = mexp_pkg::cnt_t'(W);
                to_base_next = 1'b0;
            end
            mexp_pkg::OP_SCAN_SHIFT: begin
                expo_next = {expo_reg[W-2:0], 1'b0};
                bits_next = bits_reg - mexp_pkg::cnt_t'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ucnt_reg <= '0;
            bits_reg <= '0;
            to_base_reg <= 1'b0;
        end else begin
            ucnt_reg <= ucnt_next;
            bits_reg <= bits_next;
            to_base_reg <= to_base_next;
        end
        base_reg <= base_next;
        expo_reg <= expo_next;
        modu_reg <= modu_next;
        acc_reg <= acc_next;
        prod_reg <= prod_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    always_comb begin
        status.mod_zero  = (modu_reg == '0);
        status.unit_busy = (ucnt_reg != '0);
        status.expo_top  = expo_reg[W-1];
        status.expo_zero = (expo_reg == '0);
        // more exponent bits remain below the one in the top position
        status.bits_left = (bits_reg > mexp_pkg::cnt_t'(1));
    end
    assign result = acc_reg;

    `MEC_ASSERT_IMP(a_prod_below_mod, (ucnt_reg != '0) && (modu_reg != '0), prod_reg < modu_reg, "partial product not reduced")
    `MEC_ASSERT_NEXT(a_start_idle_unit, cmd.op == mexp_pkg::OP_SQ_START, ucnt_reg == mexp_pkg::cnt_t'(W), "multiply start lost")
    `MEC_ASSERT_IMP(a_no_scan_while_busy, cmd.op == mexp_pkg::OP_SCAN_SHIFT, ucnt_reg == '0, "scan during multiply")
endmodule
`default_nettype wire

// ----- design/mexp_ctrl.sv -----
// Controller: sequences reduce, square and multiply steps over the exponent bits.
// Depends on mexp_pkg.
`default_nettype none
`include "modular_exponentiation_core_assert.svh"
module mexp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              out_ready,
    input  wire mexp_pkg::status_t status,
    output mexp_pkg::cmd_t         cmd,
    output logic                   in_ready,
    output logic                   out_valid
);
    mexp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE: begin
                if (start) state_next = mexp_pkg::ST_RED_BASE;
            end
            mexp_pkg::ST_RED_BASE: begin
                if (status.mod_zero) state_next = mexp_pkg::ST_DONE;
                else state_next = mexp_pkg::ST_FIND_MSB;
            end
            mexp_pkg::ST_FIND_MSB: begin
                // wait out base reduction, then drop leading zero bits
                if (!status.unit_busy) begin
                    if (status.expo_zero) state_next = mexp_pkg::ST_DONE;
                    else if (status.expo_top) state_next = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_SQUARE: state_next = mexp_pkg::ST_MULT;
            mexp_pkg::ST_MULT: begin
                if (!status.unit_busy) state_next = mexp_pkg::ST_NEXT_BIT;
            end
            mexp_pkg::ST_NEXT_BIT: begin
                if (!status.unit_busy) begin
                    if (status.bits_left) state_next = mexp_pkg::ST_SQUARE;
                    else state_next = mexp_pkg::ST_DONE;
                end
            end
            mexp_pkg::ST_DONE: begin
                if (out_ready) state_next = mexp_pkg::ST_IDLE;
            end
            default: state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = mexp_pkg::OP_NONE;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (start) cmd.op = mexp_pkg::OP_LOAD;
            end
            mexp_pkg::ST_RED_BASE: begin
                if (!status.mod_zero) cmd.op = mexp_pkg::OP_RED_START;
            end
            mexp_pkg::ST_FIND_MSB: begin
                if (!status.unit_busy && !status.expo_zero && !status.expo_top)
                    cmd.op = mexp_pkg::OP_SCAN_SHIFT;
            end
            mexp_pkg::ST_SQUARE: cmd.op = mexp_pkg::OP_SQ_START;
            mexp_pkg::ST_MULT: begin
                if (!status.unit_busy && status.expo_top) cmd.op = mexp_pkg::OP_MUL_START;
            end
            mexp_pkg::ST_NEXT_BIT: begin
                if (!status.unit_busy) cmd.op = mexp_pkg::OP_SCAN_SHIFT;
            end
            mexp_pkg::ST_DONE: out_valid = 1'b1;
            default: begin
            end
        endcase
    end

    `MEC_ASSERT_IMP(a_ready_only_idle, in_ready, !out_valid, "ready while holding result")
    `MEC_ASSERT_NEXT(a_done_holds, out_valid && !out_ready, out_valid, "result dropped")
    `MEC_ASSERT_IMP(a_square_unit_free, state_reg == mexp_pkg::ST_SQUARE, !status.unit_busy, "square while busy")
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for modular_exponentiation_core: square-and-multiply power checks.
// Depends on mexp_pkg and the core RTL; predicts each result with a bit-serial modular model.
`default_nettype none
module tb;
    typedef struct packed {
        logic [31:0] modulus_value;
        logic [31:0] exponent_value;
        logic [31:0] base_value;
    } power_req_t;

    typedef struct {
        logic [31:0] power_result;
        logic        modulus_error;
    } power_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mexp_pkg::TDATA_IN_WIDTH-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mexp_pkg::TDATA_OUT_WIDTH-1:0] m_tdata;

    power_req_t  pending_reqs[$];
    power_resp_t expected_powers[$];
    int unsigned errors = 0;
    int unsigned cycle_no = 0;
    bit stimulus_done = 1'b0;

    modular_exponentiation_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] room;
        room = m - y;
        return (x >= room) ? x - room : x + y;
    endfunction

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        for (int b = 63; b >= 0; b--) begin
            acc = add_mod(acc, acc, m);
            if (y[b]) acc = add_mod(acc, x, m);
        end
        return acc;
    endfunction

    function automatic power_resp_t predict_power(power_req_t r);
        power_resp_t res;
        logic [63:0] modu, acc, base_red;
        int top;
        modu = {32'd0, r.modulus_value};
        res.modulus_error = 1'b0;
        if (modu == 0) begin
            res.power_result = '0;
            res.modulus_error = 1'b1;
            return res;
        end
        acc = 64'd1 % modu;
        base_red = {32'd0, r.base_value} % modu;
        top = 0;
        for (int i = 0; i < 32; i++) if (r.exponent_value[i]) top = i + 1;
        for (int i = top; i >= 1; i--) begin
            acc = mul_mod(acc, acc, modu);
            if (r.exponent_value[i-1]) acc = mul_mod(acc, base_red, modu);
        end
        res.power_result = acc[31:0];
        return res;
    endfunction

    // Idle with a probability of about 23 percent, except in a quiet window in the middle.
    function automatic bit idle_now();
        if (cycle_no > 60000 && cycle_no < 120000) return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    // Driver: hold the item until the transfer, then advance.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_powers.push_back(predict_power(power_req_t'(s_tdata)));
                void'(pending_reqs.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // keep presenting
            end else if (pending_reqs.size() > 0 && !idle_now()) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_reqs[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each transfer with the oldest expectation.
    always @(posedge aclk) begin
        power_resp_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_powers.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors = errors + 1;
                end else begin
                    want = expected_powers.pop_front();
                    if (m_tdata[31:0] !== want.power_result) begin
                        $error("power_result expected %h got %h", want.power_result,
                               m_tdata[31:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[32] !== want.modulus_error) begin
                        $error("modulus_error expected %b got %b", want.modulus_error,
                               m_tdata[32]);
                        errors = errors + 1;
                    end
                end
            end
            m_tready <= !idle_now();
        end
    end

    function automatic power_req_t mk(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        power_req_t r;
        r.base_value = b;
        r.exponent_value = e;
        r.modulus_value = m;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(255);
            1: return 32'hFFFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] b, e, m;
        pending_reqs.push_back(mk(32'd5, 32'd3, 32'd0));
        pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
        pending_reqs.push_back(mk(32'd7, 32'd0, 32'd13));
        pending_reqs.push_back(mk(32'd7, 32'd0, 32'd1));
        pending_reqs.push_back(mk(32'd123, 32'd45, 32'd1));
        pending_reqs.push_back(mk(32'd100, 32'd7, 32'd13));
        pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB));
        pending_reqs.push_back(mk(32'd0, 32'd0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(32'd0, 32'd5, 32'd97));
        pending_reqs.push_back(mk(32'd2, 32'h8000_0000, 32'hFFFF_FFF1));
        pending_reqs.push_back(mk(32'd3, 32'd16, 32'd1000));
        pending_reqs.push_back(mk(32'd3, 32'd1, 32'd1000));
        pending_reqs.push_back(mk(32'h8000_0000, 32'd2, 32'h8000_0001));
        pending_reqs.push_back(mk(32'd5, 32'd117, 32'd19));
        repeat (125) begin
            b = rand_word();
            e = rand_word();
            m = ($urandom_range(15) == 0) ? 32'd0 : rand_word();
            pending_reqs.push_back(mk(b, e, m));
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() == 0);
        wait (expected_powers.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_powers.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
